### sv/hashed_wait_queue_table_macros.svh
// Assertion macros for the hashed wait queue table.
// Used by the top level only; depends on nothing else.
`ifndef HASHED_WAIT_QUEUE_TABLE_MACROS_SVH
`define HASHED_WAIT_QUEUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HWQ_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWQ_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

### sv/hwq_pkg.sv
// Package for the hashed wait queue table: payload types, codes, states, constants.
// Used by the channel interface and the top level.
package hwq_pkg;

    localparam int BUCKET_COUNT_DEF = 16;
    localparam int WAITER_SLOTS_DEF = 16;
    localparam int TICKS_PER_SECOND_DEF = 1000;

    localparam int MAX_WAKE = 16;
    localparam logic [30:0] NSEC_RECIP = 31'd1125899907;
    localparam int NSEC_SHIFT = 50;

    typedef enum logic [1:0] {
        OP_WAIT = 2'd0,
        OP_WAKE = 2'd1,
        OP_RETURN = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_ADDR = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_FULL = 3'd3,
        ST_TIMED_OUT = 3'd4,
        ST_INTERRUPTED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_MUL0,
        S_MUL1,
        S_ADD,
        S_INS,
        S_RESP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [63:0] address;
        logic [63:0] space_id;
        logic private_flag;
        logic [15:0] task_id;
        logic [31:0] expected_value;
        logic [31:0] current_value;
        logic timed_wait;
        logic [31:0] timeout_sec;
        logic [29:0] timeout_nsec;
        logic [63:0] now_tick;
        logic [30:0] wake_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic task_valid;
        logic [15:0] woken_task;
        logic [4:0] woken_total;
        logic last;
    } out_item_t;

endpackage

### sv/hwq_chan_if.sv
// Valid/ready channel interface carrying one payload type.
// Payload types come from hwq_pkg.
interface hwq_chan_if #(
    parameter type T = hwq_pkg::in_item_t
);
    logic valid;
    logic ready;
    T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/hashed_wait_queue_table.sv
// Top level of the hashed wait queue table: sequencer, slot memory and order list.
// Depends on hwq_pkg, hwq_chan_if and hashed_wait_queue_table_macros.svh.
//
// Channel | Direction | Payload
// in_ch   | sink      | hwq_pkg::in_item_t
// out_ch  | source    | hwq_pkg::out_item_t
//
// A wait or wake first reduces its hash to a bucket, one byte per cycle, over all eight bytes.
// A timed wait then steps through S_MUL0, S_MUL1 and S_ADD on the shared multiplier, then inserts in S_INS.
// A wake or return visits every queued entry, each in S_SCAN_RD then S_SCAN_CHK, through the
// order list and the slot memory read port; output stalls hold the scan.
// Reset clears the valid bits, the order count and the sequencer; no clearing pass.
`include "hashed_wait_queue_table_macros.svh"

module hashed_wait_queue_table #(
    parameter int BUCKET_COUNT = hwq_pkg::BUCKET_COUNT_DEF,
    parameter int WAITER_SLOTS = hwq_pkg::WAITER_SLOTS_DEF,
    parameter int TICKS_PER_SECOND = hwq_pkg::TICKS_PER_SECOND_DEF
) (
    input logic clk,
    input logic rst_n,
    hwq_chan_if.sink in_ch,
    hwq_chan_if.source out_ch
);

    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CW = $clog2(WAITER_SLOTS + 1);
    localparam logic [24:0] HASH_RECIP =
        25'(((64'd1 << 24) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

    hwq_pkg::state_t state_reg, state_next;
    hwq_pkg::in_item_t in_reg;
    hwq_pkg::out_item_t out_reg;
    logic out_valid_reg;
    logic out_load;
    logic [2:0] resp_st_reg;
    logic [63:0] hval_reg;
    logic [5:0] hcnt_reg;
    logic [BW:0] hrem_reg;
    logic [15:0] hash_dig;
    logic [40:0] hash_prod;
    logic [15:0] hash_rem;
    logic [BW:0] hrem_next;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] dl_reg;
    logic [63:0] dl_sum;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [SW-1:0] ord_reg [WAITER_SLOTS];
    logic [WAITER_SLOTS-1:0] valid_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] steps_reg;
    logic [4:0] picked_reg;
    logic [4:0] limit_reg;
    logic found_reg;
    logic [2:0] ret_st_reg;
    logic pend_valid_reg;
    logic [15:0] pend_task_reg;
    logic [4:0] pend_total_reg;
    logic [SW-1:0] free_idx;

    logic [63:0] mem_addr [WAITER_SLOTS];
    logic [63:0] mem_space [WAITER_SLOTS];
    logic [BW-1:0] mem_bucket [WAITER_SLOTS];
    logic [15:0] mem_task [WAITER_SLOTS];
    logic [63:0] mem_dl [WAITER_SLOTS];
    logic mem_timed [WAITER_SLOTS];
    logic [63:0] rd_addr;
    logic [63:0] rd_space;
    logic [BW-1:0] rd_bucket;
    logic [15:0] rd_task;
    logic [63:0] rd_dl;
    logic rd_timed;

    logic in_accept;
    logic out_free;
    logic in_bad;
    logic live_bad;
    logic is_wake;
    logic chk_match;
    logic chk_go;
    logic full;
    logic [63:0] live_hash;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign full = (cnt_reg == CW'(WAITER_SLOTS));
    assign live_bad = (in_ch.data.address[1:0] != 2'b00) || (in_ch.data.address == 64'd0);
    assign in_bad = live_bad;
    assign is_wake = (in_reg.operation == hwq_pkg::OP_WAKE);
    assign live_hash = {2'b00, in_ch.data.address[63:2]}
        ^ (in_ch.data.private_flag ? 64'd0 : {12'd0, in_ch.data.space_id[63:12]});

    // The bucket is reduced one byte at a time, most significant byte first.
    assign hash_dig = {8'(hrem_reg), hval_reg[63:56]};
    assign hash_prod = 41'(hash_dig) * 41'(HASH_RECIP);
    assign hash_rem = hash_dig - 16'(hash_prod[39:24] * 16'(BUCKET_COUNT));
    assign hrem_next = (BW+1)'(hash_rem);

    assign dl_sum = acc_reg + (prod_reg >> hwq_pkg::NSEC_SHIFT);

    always_comb
    begin
        free_idx = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        if (is_wake)
        begin
            chk_match = (rd_bucket == hrem_reg[BW-1:0]) && (rd_addr == in_reg.address)
                && (in_reg.private_flag || (rd_space == in_reg.space_id))
                && (picked_reg < limit_reg);
        end
        else
        begin
            chk_match = (rd_task == in_reg.task_id) && !found_reg;
        end
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ch.ready = (state_reg == hwq_pkg::S_IDLE);
        chk_go = !(is_wake && chk_match && pend_valid_reg && !out_free);
        mul_a = in_reg.timeout_sec;
        mul_b = 32'(TICKS_PER_SECOND);
        if (state_reg == hwq_pkg::S_MUL1)
        begin
            mul_a = {2'b00, in_reg.timeout_nsec};
            mul_b = {1'b0, hwq_pkg::NSEC_RECIP};
        end
        out_load = 1'b0;
        if ((state_reg == hwq_pkg::S_RESP) || (state_reg == hwq_pkg::S_FLUSH))
        begin
            out_load = out_free;
        end
        else if (state_reg == hwq_pkg::S_SCAN_CHK)
        begin
            out_load = chk_go && chk_match && is_wake && pend_valid_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hwq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_ch.data.operation)
                        hwq_pkg::OP_WAIT:
                        begin
                            if (in_bad || (in_ch.data.current_value != in_ch.data.expected_value)
                                || full)
                            begin
                                state_next = hwq_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = hwq_pkg::S_HASH;
                            end
                        end
                        hwq_pkg::OP_WAKE:
                        begin
                            state_next = in_bad ? hwq_pkg::S_RESP : hwq_pkg::S_HASH;
                        end
                        hwq_pkg::OP_RETURN:
                        begin
                            state_next = (cnt_reg == '0) ? hwq_pkg::S_FLUSH : hwq_pkg::S_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = hwq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hwq_pkg::S_HASH:
            begin
                if (hcnt_reg == 6'd7)
                begin
                    if (is_wake)
                    begin
                        state_next = (cnt_reg == '0) ? hwq_pkg::S_FLUSH : hwq_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = in_reg.timed_wait ? hwq_pkg::S_MUL0 : hwq_pkg::S_INS;
                    end
                end
            end
            hwq_pkg::S_MUL0: state_next = hwq_pkg::S_MUL1;
            hwq_pkg::S_MUL1: state_next = hwq_pkg::S_ADD;
            hwq_pkg::S_ADD: state_next = hwq_pkg::S_INS;
            hwq_pkg::S_INS: state_next = hwq_pkg::S_RESP;
            hwq_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = hwq_pkg::S_IDLE;
                end
            end
            hwq_pkg::S_SCAN_RD: state_next = hwq_pkg::S_SCAN_CHK;
            hwq_pkg::S_SCAN_CHK:
            begin
                if (chk_go)
                begin
                    state_next = (steps_reg == CW'(1)) ? hwq_pkg::S_FLUSH : hwq_pkg::S_SCAN_RD;
                end
            end
            hwq_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = hwq_pkg::S_IDLE;
                end
            end
            default: state_next = hwq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hwq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg <= '0;
            cnt_reg <= '0;
            pend_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                hwq_pkg::S_IDLE:
                begin
                    if (in_accept)
                    begin
                        pend_valid_reg <= 1'b0;
                        found_reg <= 1'b0;
                    end
                end
                hwq_pkg::S_INS:
                begin
                    valid_reg[free_idx] <= 1'b1;
                    cnt_reg <= cnt_reg + CW'(1);
                end
                hwq_pkg::S_SCAN_CHK:
                begin
                    if (chk_go && chk_match)
                    begin
                        valid_reg[ord_reg[0]] <= 1'b0;
                        cnt_reg <= cnt_reg - CW'(1);
                        if (is_wake)
                        begin
                            pend_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        rd_addr <= mem_addr[ord_reg[0]];
        rd_space <= mem_space[ord_reg[0]];
        rd_bucket <= mem_bucket[ord_reg[0]];
        rd_task <= mem_task[ord_reg[0]];
        rd_dl <= mem_dl[ord_reg[0]];
        rd_timed <= mem_timed[ord_reg[0]];
        case (state_reg)
            hwq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    in_reg <= in_ch.data;
                    hval_reg <= live_hash;
                    hcnt_reg <= '0;
                    hrem_reg <= '0;
                    dl_reg <= '0;
                    steps_reg <= cnt_reg;
                    picked_reg <= '0;
                    ret_st_reg <= hwq_pkg::ST_OK;
                    limit_reg <= (in_ch.data.wake_count < 31'(hwq_pkg::MAX_WAKE))
                        ? in_ch.data.wake_count[4:0] : 5'(hwq_pkg::MAX_WAKE);
                    if (in_bad)
                    begin
                        resp_st_reg <= hwq_pkg::ST_BAD_ADDR;
                    end
                    else if (in_ch.data.current_value != in_ch.data.expected_value)
                    begin
                        resp_st_reg <= hwq_pkg::ST_MISMATCH;
                    end
                    else if (full)
                    begin
                        resp_st_reg <= hwq_pkg::ST_FULL;
                    end
                    else
                    begin
                        resp_st_reg <= hwq_pkg::ST_OK;
                    end
                end
            end
            hwq_pkg::S_HASH:
            begin
                hrem_reg <= hrem_next;
                hval_reg <= {hval_reg[55:0], 8'd0};
                hcnt_reg <= hcnt_reg + 6'd1;
            end
            hwq_pkg::S_MUL1:
            begin
                acc_reg <= prod_reg + in_reg.now_tick;
            end
            hwq_pkg::S_ADD:
            begin
                dl_reg <= (dl_sum == 64'd0) ? 64'd1 : dl_sum;
            end
            hwq_pkg::S_INS:
            begin
                mem_addr[free_idx] <= in_reg.address;
                mem_space[free_idx] <= in_reg.space_id;
                mem_bucket[free_idx] <= hrem_reg[BW-1:0];
                mem_task[free_idx] <= in_reg.task_id;
                mem_dl[free_idx] <= dl_reg;
                mem_timed[free_idx] <= in_reg.timed_wait;
                ord_reg[0] <= free_idx;
                for (int p = 1; p < WAITER_SLOTS; p++)
                begin
                    ord_reg[p] <= ord_reg[p-1];
                end
                resp_st_reg <= hwq_pkg::ST_OK;
            end
            hwq_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_reg <= '{status: resp_st_reg, task_valid: 1'b0, woken_task: 16'd0,
                                 woken_total: 5'd0, last: 1'b1};
                end
            end
            hwq_pkg::S_SCAN_CHK:
            begin
                if (chk_go)
                begin
                    steps_reg <= steps_reg - CW'(1);
                    for (int p = 0; p < WAITER_SLOTS; p++)
                    begin
                        if ((CW'(p) + CW'(1) == cnt_reg) && !chk_match)
                        begin
                            ord_reg[p] <= ord_reg[0];
                        end
                        else if (p < WAITER_SLOTS - 1)
                        begin
                            ord_reg[p] <= ord_reg[(p < WAITER_SLOTS - 1) ? p + 1 : p];
                        end
                    end
                    if (chk_match)
                    begin
                        if (is_wake)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg <= '{status: hwq_pkg::ST_OK, task_valid: 1'b1,
                                             woken_task: pend_task_reg,
                                             woken_total: pend_total_reg, last: 1'b0};
                            end
                            pend_task_reg <= rd_task;
                            pend_total_reg <= picked_reg + 5'd1;
                            picked_reg <= picked_reg + 5'd1;
                        end
                        else
                        begin
                            ret_st_reg <= (rd_timed && (in_reg.now_tick >= rd_dl))
                                ? hwq_pkg::ST_TIMED_OUT : hwq_pkg::ST_INTERRUPTED;
                        end
                    end
                end
            end
            hwq_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    if (is_wake && pend_valid_reg)
                    begin
                        out_reg <= '{status: hwq_pkg::ST_OK, task_valid: 1'b1,
                                     woken_task: pend_task_reg,
                                     woken_total: pend_total_reg, last: 1'b1};
                    end
                    else
                    begin
                        out_reg <= '{status: is_wake ? 3'(hwq_pkg::ST_OK) : ret_st_reg,
                                     task_valid: 1'b0, woken_task: 16'd0,
                                     woken_total: 5'd0, last: 1'b1};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    `HWQ_ASSERT_IMP(a_cnt_matches_valid, clk, rst_n, 1'b1, cnt_reg == CW'($countones(valid_reg)), "queue count disagrees with valid bits")
    `HWQ_ASSERT_IMP(a_cnt_bounded, clk, rst_n, 1'b1, cnt_reg <= CW'(WAITER_SLOTS), "queue count exceeds slots")
    `HWQ_ASSERT_NXT(a_insert_grows, clk, rst_n, state_reg == hwq_pkg::S_INS, cnt_reg == $past(cnt_reg) + CW'(1), "insert did not grow the queue")
    `HWQ_ASSERT_IMP(a_no_insert_full, clk, rst_n, state_reg == hwq_pkg::S_INS, !full, "insert into a full table")

endmodule

### tb/tb_top.sv
// Testbench for hashed_wait_queue_table: random and directed waits, wakes and returns.
// Depends on hwq_pkg and hwq_chan_if; a scoreboard class predicts every result.
module tb_top;
    import hwq_pkg::*;

    localparam int SLOTS = 16;
    localparam int BUCKETS = 16;
    localparam int TICKS_SEC = 1000;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 120;

    class wait_table_scoreboard;
        bit              used[SLOTS];
        logic [63:0]     addr_q[SLOTS];
        logic [63:0]     space_q[SLOTS];
        logic [3:0]      bucket_q[SLOTS];
        logic [15:0]     task_q[SLOTS];
        logic [63:0]     deadline_q[SLOTS];
        bit              timed_q[SLOTS];
        int              age_q[SLOTS];
        out_item_t       expected_results[$];
        int              errors;

        function automatic logic [3:0] bucket(logic [63:0] a, logic [63:0] s, logic p);
            logic [63:0] sp;
            sp = p ? 64'd0 : s;
            return 4'(((a >> 2) ^ (sp >> 12)) % BUCKETS);
        endfunction

        function automatic void push_result(status_t st, logic tv, logic [15:0] tk,
                                            logic [4:0] tot, logic lst);
            out_item_t r;
            r.status = st;
            r.task_valid = tv;
            r.woken_task = tk;
            r.woken_total = tot;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function automatic void remove_slot(int i);
            int a;
            a = age_q[i];
            used[i] = 0;
            for (int j = 0; j < SLOTS; j++)
                if (used[j] && age_q[j] > a)
                    age_q[j]--;
        endfunction

        function automatic void note_input(in_item_t it);
            logic        bad;
            int          free_i;
            int          found;
            int          picks[$];
            int          lim;
            int          s;
            logic [63:0] dl;
            logic [3:0]  b;
            bad = (it.address[1:0] != 2'd0) || (it.address == 64'd0);
            case (op_t'(it.operation))
                OP_WAIT:
                begin
                    free_i = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!used[i])
                            free_i = i;
                    if (bad)
                        push_result(ST_BAD_ADDR, 0, 0, 0, 1);
                    else if (it.current_value != it.expected_value)
                        push_result(ST_MISMATCH, 0, 0, 0, 1);
                    else if (free_i < 0)
                        push_result(ST_FULL, 0, 0, 0, 1);
                    else
                    begin
                        dl = 64'd0;
                        if (it.timed_wait)
                        begin
                            dl = 64'(it.timeout_sec) * TICKS_SEC
                                 + 64'(it.timeout_nsec / 1000000) + it.now_tick;
                            if (dl == 64'd0)
                                dl = 64'd1;
                        end
                        for (int i = 0; i < SLOTS; i++)
                            if (used[i])
                                age_q[i]++;
                        used[free_i] = 1;
                        age_q[free_i] = 0;
                        addr_q[free_i] = it.address;
                        space_q[free_i] = it.space_id;
                        bucket_q[free_i] = bucket(it.address, it.space_id, it.private_flag);
                        task_q[free_i] = it.task_id;
                        deadline_q[free_i] = dl;
                        timed_q[free_i] = it.timed_wait;
                        push_result(ST_OK, 0, 0, 0, 1);
                    end
                end
                OP_WAKE:
                begin
                    if (bad)
                        push_result(ST_BAD_ADDR, 0, 0, 0, 1);
                    else
                    begin
                        lim = (it.wake_count < MAX_WAKE) ? int'(it.wake_count) : MAX_WAKE;
                        b = bucket(it.address, it.space_id, it.private_flag);
                        for (int age = 0; age < SLOTS && picks.size() < lim; age++)
                        begin
                            s = -1;
                            for (int i = 0; i < SLOTS; i++)
                                if (used[i] && age_q[i] == age)
                                    s = i;
                            if (s < 0)
                                break;
                            if (bucket_q[s] == b && addr_q[s] == it.address &&
                                (it.private_flag || space_q[s] == it.space_id))
                                picks.push_back(s);
                        end
                        if (picks.size() == 0)
                            push_result(ST_OK, 0, 0, 0, 1);
                        for (int i = 0; i < picks.size(); i++)
                            push_result(ST_OK, 1, task_q[picks[i]], 5'(i + 1),
                                        i == picks.size() - 1);
                        for (int i = picks.size() - 1; i >= 0; i--)
                            remove_slot(picks[i]);
                    end
                end
                OP_RETURN:
                begin
                    found = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i] && task_q[i] == it.task_id &&
                            (found < 0 || age_q[i] < age_q[found]))
                            found = i;
                    if (found < 0)
                        push_result(ST_OK, 0, 0, 0, 1);
                    else
                    begin
                        if (timed_q[found] && it.now_tick >= deadline_q[found])
                            push_result(ST_TIMED_OUT, 0, 0, 0, 1);
                        else
                            push_result(ST_INTERRUPTED, 0, 0, 0, 1);
                        remove_slot(found);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function automatic void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status=%0d task_valid=%0d task=%0h total=%0d last=%0d",
                             got.status, got.task_valid, got.woken_task, got.woken_total, got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status || got.task_valid != want.task_valid ||
                got.woken_task != want.woken_task || got.woken_total != want.woken_total ||
                got.last != want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("result differs: expected %0d/%0d/%0h/%0d/%0d got %0d/%0d/%0h/%0d/%0d",
                             want.status, want.task_valid, want.woken_task, want.woken_total,
                             want.last, got.status, got.task_valid, got.woken_task,
                             got.woken_total, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    hwq_chan_if #(.T(in_item_t)) in_ch();
    hwq_chan_if #(.T(out_item_t)) out_ch();

    hashed_wait_queue_table u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    wait_table_scoreboard sb = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          cycle_count;
    logic [63:0] now_base;
    logic [63:0] addr_pool[4] = '{64'h1000, 64'h2004, 64'hFFFF_FFFF_FFFF_FFFC, 64'h4};
    logic [63:0] space_pool[3] = '{64'h0, 64'h5000, 64'hFFFF_FFFF_FFFF_FFFF};

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("hashed_wait_queue_table: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t plain_item(op_t op, logic [63:0] a, logic [15:0] tk);
        in_item_t it;
        it = '0;
        it.operation = op;
        it.address = a;
        it.task_id = tk;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       sel;
        sel = $urandom_range(99);
        it.operation = (sel < 45) ? OP_WAIT : (sel < 75) ? OP_WAKE : (sel < 96) ? OP_RETURN
                     : OP_NONE;
        it.address = ($urandom_range(99) < 88) ? addr_pool[$urandom_range(3)] : rand64();
        it.space_id = ($urandom_range(99) < 90) ? space_pool[$urandom_range(2)] : rand64();
        it.private_flag = $urandom_range(1);
        it.task_id = ($urandom_range(99) < 85) ? 16'($urandom_range(7)) : 16'($urandom);
        it.expected_value = $urandom;
        it.current_value = ($urandom_range(99) < 85) ? it.expected_value : $urandom;
        it.timed_wait = $urandom_range(1);
        it.timeout_sec = ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom;
        it.timeout_nsec = $urandom_range(999999999);
        now_base = now_base + $urandom_range(3000);
        it.now_tick = ($urandom_range(99) < 92) ? now_base : rand64();
        it.wake_count = ($urandom_range(99) < 85) ? 31'($urandom_range(20)) : 31'($urandom);
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic run_directed();
        in_item_t it;
        send_item(plain_item(OP_WAIT, 64'd0, 16'd0));
        send_item(plain_item(OP_WAIT, 64'd6, 16'd0));
        send_item(plain_item(OP_WAKE, 64'd1, 16'd0));
        it = plain_item(OP_WAIT, addr_pool[0], 16'd0);
        it.current_value = 32'hFFFF_FFFF;
        send_item(it);
        it = plain_item(OP_WAIT, addr_pool[0], 16'd1);
        it.timed_wait = 1'b1;
        send_item(it);
        it = plain_item(OP_WAIT, addr_pool[2], 16'hFFFF);
        it.timed_wait = 1'b1;
        it.space_id = '1;
        it.timeout_sec = '1;
        it.timeout_nsec = 30'd999999999;
        it.now_tick = '1;
        it.expected_value = '1;
        it.current_value = '1;
        send_item(it);
        for (int k = 2; k < 16; k++)
            send_item(plain_item(OP_WAIT, addr_pool[0], 16'(k)));
        send_item(plain_item(OP_WAIT, addr_pool[1], 16'd40));
        send_item(plain_item(OP_WAKE, addr_pool[0], 16'd0));
        it = plain_item(OP_RETURN, 64'd0, 16'd1);
        it.now_tick = 64'd5;
        send_item(it);
        send_item(plain_item(OP_RETURN, 64'd0, 16'hFFFF));
        send_item(plain_item(OP_RETURN, 64'd0, 16'd999));
        send_item(plain_item(OP_NONE, '1, '1));
        it = plain_item(OP_WAKE, addr_pool[0], 16'd0);
        it.private_flag = 1'b1;
        it.wake_count = '1;
        send_item(it);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        now_base = 64'd100;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 77 : (phase == 3) ? 24 : 0;
            recv_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 24 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 20)
                    hold_left = 600;
                if (phase == 1 && n == 60)
                begin
                    in_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (sb.expected_results.size() != 0)
                        @(posedge clk);
                end
                send_item(random_item());
            end
        end
        in_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("hashed_wait_queue_table: match");
        else
            $display("hashed_wait_queue_table: mismatch");
        $finish;
    end
endmodule
